// ===== rtl/frba_pkg.sv =====
// Shared types and codes for the free-run block allocator.
`timescale 1ns / 1ps

package frba_pkg;

   // Table depth and field widths
   localparam int BLOCKS       = 1024;
   localparam int BLK_W        = 10;
   localparam int SIZE_W       = 11;
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 2;

   // Volume size limits
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_FORMAT  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // Count saturation value
   localparam logic [BLK_W-1:0] COUNT_MAX = {BLK_W{1'b1}};

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [BLK_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [BLK_W-1:0]    granted_block;
      logic [STATUS_W-1:0] status;
      logic [BLK_W-1:0]    free_left;
   } rsp_type;

   // Run descriptor: next run's first block over the run length
   typedef struct packed {
      logic [BLK_W-1:0] next_block;
      logic [BLK_W-1:0] run_len;
   } run_entry_type;

endpackage

// ===== rtl/frba_run_table.sv =====
// Run descriptor memory: one write port, one registered read port.
`timescale 1ns / 1ps

module frba_run_table
   import frba_pkg::*;
(
   input  logic          clock,
   input  logic          rd_en,
   input  logic [BLK_W-1:0] rd_addr,
   output run_entry_type rd_data,
   input  logic          wr_en,
   input  logic [BLK_W-1:0] wr_addr,
   input  run_entry_type wr_data
);

   run_entry_type mem [BLOCKS];
   run_entry_type rd_data_ff;

   // Write descriptor
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read descriptor, hold data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/free_run_block_allocator.sv =====
// Free-run block allocator: usage notes at the head of this file.
//
// Channels: req (op, block_index) in, rsp (granted_block, status, free_left)
// out, both valid/ready. One response per request, in order. csr writes the
// volume size in blocks (11 bits); write it only while no request is open.
// Per request, the head run descriptor is read from the run table in the
// cycle the request is taken; then, in the update state, the descriptor is
// updated, written back and the response is registered. The single table
// read port and the read-modify-write on it mean that a new request is not
// taken until the previous one has been written back.
// A response waiting in the output register does not block the next
// request from being taken; if the receiver stalls, the following request
// holds in its update cycle until the output register frees up.
// Reset empties the free list (volume reads as full) and sets the volume
// size to 1024. The run table is not cleared: issue format before allocate
// or release.
`timescale 1ns / 1ps

module free_run_block_allocator
   import frba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_data
);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_EXEC = 1'b1;

   logic              state_ff,  state_in;
   logic [BLK_W-1:0]  head_ff,   head_in;
   logic [BLK_W-1:0]  count_ff,  count_in;
   logic [SIZE_W-1:0] volume_ff;
   req_type           req_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff,    rsp_in;

   logic              req_take;
   logic              exec_done;
   logic [SIZE_W-1:0] size_eff;
   run_entry_type     rd_entry;
   logic              wr_en;
   logic [BLK_W-1:0]  wr_addr;
   run_entry_type     wr_entry;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == STATE_IDLE);
   assign req_take  = req_valid & req_ready;
   assign exec_done = (state_ff == STATE_EXEC) & (~rsp_valid_ff | rsp_ready);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Clamp the volume size into its legal range
   always_comb begin
      if (volume_ff < SIZE_MIN) begin
         size_eff = SIZE_MIN;
      end else if (volume_ff > SIZE_MAX) begin
         size_eff = SIZE_MAX;
      end else begin
         size_eff = volume_ff;
      end
   end

   frba_run_table u_run_table (
      .clock   (clock),
      .rd_en   (req_take),
      .rd_addr (head_ff),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry)
   );

   // Apply the request to the free list
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      wr_entry = rd_entry;
      rsp_in   = rsp_ff;
      if (exec_done) begin
         rsp_in.granted_block = '0;
         rsp_in.status        = ST_OK;
         unique case (req_ff.op)
            OP_ALLOC: begin
               if (count_ff == '0) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.granted_block = head_ff;
                  count_in = count_ff - BLK_W'(1);
                  if (rd_entry.run_len <= BLK_W'(1)) begin
                     head_in = rd_entry.next_block;
                  end else begin
                     // Move the descriptor one block on
                     head_in             = head_ff + BLK_W'(1);
                     wr_en               = 1'b1;
                     wr_addr             = head_ff + BLK_W'(1);
                     wr_entry.run_len    = rd_entry.run_len - BLK_W'(1);
                     wr_entry.next_block = rd_entry.next_block;
                  end
               end
            end
            OP_RELEASE: begin
               if (req_ff.block_index == '0) begin
                  rsp_in.status = ST_ZERO;
               end else if ({1'b0, req_ff.block_index} >= size_eff) begin
                  rsp_in.status = ST_RANGE;
               end else begin
                  // Push a one-block run at the head
                  wr_en               = 1'b1;
                  wr_addr             = req_ff.block_index;
                  wr_entry.run_len    = BLK_W'(1);
                  wr_entry.next_block = head_ff;
                  head_in             = req_ff.block_index;
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + BLK_W'(1);
                  end
               end
            end
            OP_FORMAT: begin
               head_in             = BLK_W'(1);
               count_in            = BLK_W'(size_eff - SIZE_W'(1));
               wr_en               = 1'b1;
               wr_addr             = BLK_W'(1);
               wr_entry.run_len    = BLK_W'(size_eff - SIZE_W'(1));
               wr_entry.next_block = '0;
            end
            OP_NONE: begin
            end
            default: begin
            end
         endcase
         rsp_in.free_left = count_in;
      end
   end

   // Advance the sequencer and the output register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff & rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_take) begin
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            if (exec_done) begin
               state_in     = STATE_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         volume_ff    <= SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         if (csr_valid & csr_ready) begin
            volume_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

endmodule

// ===== dv/tb_free_run_block_allocator.sv =====
// Testbench for the free-run block allocator: scoreboard against a run-list predictor.
`timescale 1ns / 1ps

module tb_free_run_block_allocator;
   import frba_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER  = 120;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_data  = '0;

   free_run_block_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Predicted allocator state
   run_entry_type     run_desc [BLOCKS];
   logic [BLK_W-1:0]  list_head      = '0;
   logic [BLK_W-1:0]  spare_count    = '0;
   logic [SIZE_W-1:0] volume_setting = SIZE_RESET;

   req_type req_backlog [$];
   rsp_type awaited_rsp [$];
   rsp_type want;

   int  req_gap    = 0;
   int  rsp_gap    = 0;
   int  req_taken  = 0;
   int  hold_left  = 0;
   bit  hold_done  = 1'b0;
   bit  steady     = 1'b0;
   int  err_count  = 0;
   int  cycles     = 0;

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [SIZE_W-1:0] usable_size(input logic [SIZE_W-1:0] v);
      if (v < SIZE_MIN)
         return SIZE_MIN;
      if (v > SIZE_MAX)
         return SIZE_MAX;
      return v;
   endfunction

   // Mostly short gaps, a few long ones, none in steady phases
   function automatic int idle_len();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report(input string msg);
      err_count++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // Apply one request to the predicted run list and queue its response
   task automatic predict_allocation(input req_type rq);
      rsp_type           r;
      run_entry_type     ent;
      logic [BLK_W-1:0]  nh;
      logic [SIZE_W-1:0] sz;
      sz = usable_size(volume_setting);
      r = '0;
      r.status = ST_OK;
      case (rq.op)
         OP_ALLOC: begin
            if (spare_count == '0) begin
               r.status = ST_FULL;
            end else begin
               ent = run_desc[list_head];
               r.granted_block = list_head;
               spare_count = spare_count - 1'b1;
               if (ent.run_len <= BLK_W'(1)) begin
                  list_head = ent.next_block;
               end else begin
                  nh = list_head + 1'b1;
                  list_head = nh;
                  run_desc[nh] = '{next_block: ent.next_block, run_len: ent.run_len - 1'b1};
               end
            end
         end
         OP_RELEASE: begin
            if (rq.block_index == '0) begin
               r.status = ST_ZERO;
            end else if ({1'b0, rq.block_index} >= sz) begin
               r.status = ST_RANGE;
            end else begin
               run_desc[rq.block_index] = '{next_block: list_head, run_len: BLK_W'(1)};
               list_head = rq.block_index;
               if (spare_count != COUNT_MAX)
                  spare_count = spare_count + 1'b1;
            end
         end
         OP_FORMAT: begin
            list_head = BLK_W'(1);
            spare_count = BLK_W'(sz - 1'b1);
            run_desc[1] = '{next_block: '0, run_len: spare_count};
         end
         default: ;
      endcase
      r.free_left = spare_count;
      awaited_rsp.push_back(r);
   endtask

   // Request driver: take from the backlog, hold until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_allocation(req_data);
            req_taken <= req_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
               req_gap = idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // One long receiver stall so the block backs up into the request side
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && req_taken >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: compare against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               report("response with no request outstanding");
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.granted_block !== want.granted_block)
                  report($sformatf("granted_block %0d, expected %0d",
                                   rsp_data.granted_block, want.granted_block));
               if (rsp_data.status !== want.status)
                  report($sformatf("status %0d, expected %0d",
                                   rsp_data.status, want.status));
               if (rsp_data.free_left !== want.free_left)
                  report($sformatf("free_left %0d, expected %0d",
                                   rsp_data.free_left, want.free_left));
            end
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready)
               rsp_gap = idle_len();
         end
      end
   end

   task automatic add_req(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk);
      req_type rq;
      rq.op = op;
      rq.block_index = blk;
      req_backlog.push_back(rq);
   endtask

   // Wait until every request has been answered;
   // check on the falling edge so the driver and monitor have settled
   task automatic settle();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || awaited_rsp.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_volume(input logic [SIZE_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      volume_setting = v;
   endtask

   // Format, then a mix of allocates, releases mostly inside the volume, formats and no-ops
   task automatic add_random_phase(input logic [SIZE_W-1:0] v, input int n);
      logic [SIZE_W-1:0] eff;
      int                r;
      eff = usable_size(v);
      add_req(OP_FORMAT, BLK_W'($urandom_range(0, 1023)));
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 46) begin
            add_req(OP_ALLOC, BLK_W'($urandom_range(0, 1023)));
         end else if (r < 88) begin
            r = $urandom_range(0, 99);
            if (r < 75)
               add_req(OP_RELEASE, BLK_W'($urandom_range(1, eff - 1)));
            else if (r < 85)
               add_req(OP_RELEASE, '0);
            else
               add_req(OP_RELEASE, BLK_W'($urandom_range(0, 1023)));
         end else if (r < 97) begin
            add_req(OP_FORMAT, BLK_W'($urandom_range(0, 1023)));
         end else begin
            add_req(OP_NONE, BLK_W'($urandom_range(0, 1023)));
         end
      end
   endtask

   logic [SIZE_W-1:0] phase_size [10];

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset-time size: format, walk the run, zero and top-block releases
      add_req(OP_FORMAT, '1);
      add_req(OP_ALLOC, '0);
      add_req(OP_ALLOC, '0);
      add_req(OP_ALLOC, '0);
      add_req(OP_RELEASE, '0);
      add_req(OP_RELEASE, '1);
      add_req(OP_RELEASE, BLK_W'(2));
      add_req(OP_ALLOC, '0);
      add_req(OP_ALLOC, '0);
      add_req(OP_ALLOC, '0);
      add_req(OP_NONE, '1);
      add_req(OP_RELEASE, BLK_W'(1));
      add_req(OP_ALLOC, '0);
      settle();

      // Shrink without format: head now lies beyond the volume
      write_volume(SIZE_W'(4));
      add_req(OP_ALLOC, '0);
      add_req(OP_RELEASE, BLK_W'(4));
      add_req(OP_RELEASE, BLK_W'(3));
      settle();

      // Smallest volume: full, double release of the same block
      write_volume(SIZE_MIN);
      add_req(OP_FORMAT, '0);
      add_req(OP_ALLOC, '0);
      add_req(OP_ALLOC, '0);
      add_req(OP_RELEASE, BLK_W'(1));
      add_req(OP_RELEASE, BLK_W'(1));
      add_req(OP_ALLOC, '0);
      add_req(OP_ALLOC, '0);
      add_req(OP_ALLOC, '0);
      settle();

      // Size below the minimum clips up
      write_volume('0);
      add_req(OP_FORMAT, '0);
      add_req(OP_RELEASE, BLK_W'(2));
      settle();

      // Size above the maximum clips down; release into a full count saturates
      write_volume('1);
      add_req(OP_FORMAT, '0);
      add_req(OP_RELEASE, BLK_W'(1));
      settle();

      phase_size[0] = SIZE_W'(3);
      phase_size[1] = SIZE_MAX;
      phase_size[2] = '0;
      phase_size[3] = SIZE_W'(9);
      phase_size[4] = SIZE_W'($urandom_range(2, 64));
      phase_size[5] = '1;
      phase_size[6] = SIZE_W'($urandom_range(0, 2047));
      phase_size[7] = SIZE_MIN;
      phase_size[8] = SIZE_W'($urandom_range(2, 1024));
      phase_size[9] = SIZE_W'(16);

      for (int p = 0; p < 10; p++) begin
         steady = (p % 3 == 2);
         write_volume(phase_size[p]);
         add_random_phase(phase_size[p], 101);
         settle();
      end

      repeat (10) @(posedge clock);
      if (err_count == 0 && awaited_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
